/* rtl/core/cot_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the onset taper.
`default_nettype none

package cot_pkg;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_TAPER_SAMPLES = 1'b0,
    REG_LEVEL_OFFSET  = 1'b1
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROT,
    ST_SQR,
    ST_WGT,
    ST_MAG,
    ST_SUM,
    ST_DONE
  } state_e;

  // CORDIC datapath: quarter turn is 2^30, x/y in signed Q3.30
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned STEP_W       = 5;
  localparam int unsigned ANG_FRAC     = 30;
  localparam int unsigned ANG_W        = 33;
  localparam int unsigned XY_W         = 34;
  localparam int unsigned SIN_W        = 31;
  localparam int unsigned ATAN_W       = 31;

  localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [XY_W-1:0] SIN_ONE   = 34'sd1073741824;

  function automatic logic [ATAN_W-1:0] atan_units(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 31'd536870912;
      5'd1:    val = 31'd316933406;
      5'd2:    val = 31'd167458907;
      5'd3:    val = 31'd85004756;
      5'd4:    val = 31'd42667331;
      5'd5:    val = 31'd21354465;
      5'd6:    val = 31'd10679838;
      5'd7:    val = 31'd5340245;
      5'd8:    val = 31'd2670163;
      5'd9:    val = 31'd1335087;
      5'd10:   val = 31'd667544;
      5'd11:   val = 31'd333772;
      5'd12:   val = 31'd166886;
      5'd13:   val = 31'd83443;
      5'd14:   val = 31'd41722;
      5'd15:   val = 31'd20861;
      5'd16:   val = 31'd10430;
      5'd17:   val = 31'd5215;
      5'd18:   val = 31'd2608;
      5'd19:   val = 31'd1304;
      5'd20:   val = 31'd652;
      5'd21:   val = 31'd326;
      5'd22:   val = 31'd163;
      5'd23:   val = 31'd81;
      5'd24:   val = 31'd41;
      5'd25:   val = 31'd20;
      5'd26:   val = 31'd10;
      5'd27:   val = 31'd5;
      5'd28:   val = 31'd3;
      5'd29:   val = 31'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/cosine_onset_taper_unit.sv */
// Half-Hann onset taper: sequencer, shared multiplier and top-level ports.
// Tapered sample: accept, k/N divider, 30-step CORDIC, then square, weight, product and
//   sum, then load into the output register once it is free.
// Pass-through sample: accept, then load into the output register once it is free.
// Throughput: one transaction at a time; a new sample is accepted only after the last one
//   has been loaded into the output register, which waits for that register to drain.
// Reset (async, active low): taper length, offset and sample index clear to 0, no output.
`default_nettype none

module cosine_onset_taper_unit #(
  parameter int unsigned SAMPLE_WIDTH     = 24,
  parameter int unsigned COUNT_WIDTH      = 20,
  parameter int unsigned WEIGHT_FRAC_BITS = 16,
  localparam int unsigned CFG_W = (COUNT_WIDTH > SAMPLE_WIDTH) ? COUNT_WIDTH : SAMPLE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  cot_pkg::cfg_reg_e              cfg_addr_i,
  input  logic [CFG_W-1:0]               cfg_data_i,
  // input samples
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  // output samples
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           in_taper_o
);

  import cot_pkg::*;

  localparam int unsigned SW   = SAMPLE_WIDTH;
  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned F    = WEIGHT_FRAC_BITS;
  // shared multiplier: operand a carries |d| or the sine, b the sine or the weight
  localparam int unsigned MA_W = (SW + 1 > SIN_W) ? SW + 1 : SIN_W;
  localparam int unsigned MB_W = SIN_W;
  localparam int unsigned P_W  = MA_W + MB_W;
  // s*s is Q2.60 (at most 1.0); the weight is its top F fraction bits
  localparam int unsigned W_LO = 2 * ANG_FRAC - F;

  // ---------------------------------------------------------------------------
  // Configuration and sample index
  // ---------------------------------------------------------------------------
  logic [CW-1:0]        taper_n_q;
  logic signed [SW-1:0] offset_q;
  logic [CW-1:0]        idx_q, idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taper_n_q <= '0;
      offset_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_TAPER_SAMPLES: taper_n_q <= cfg_data_i[CW-1:0];
        REG_LEVEL_OFFSET:  offset_q  <= $signed(cfg_data_i[SW-1:0]);
        default:           ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;

  logic in_accept;
  logic taper_hit;
  logic out_free;
  logic div_start, div_done;
  logic cor_start, cor_done;
  logic mul_en, mul_sel_mag;
  logic wgt_en, sum_en, out_load;

  logic [F-1:0]            quo;
  logic [SIN_W-1:0]        sin_val;
  logic signed [ANG_W-1:0] z0;

  assign in_accept = in_valid_i && in_ready_o;
  // index below length: this sample gets a weight (length zero never tapers)
  assign taper_hit = (idx_q < taper_n_q);
  assign out_free  = !out_valid_o || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_accept) state_d = taper_hit ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_done)  state_d = ST_ROT;
      ST_ROT:  if (cor_done)  state_d = ST_SQR;
      ST_SQR:  state_d = ST_WGT;
      ST_WGT:  state_d = ST_MAG;
      ST_MAG:  state_d = ST_SUM;
      ST_SUM:  state_d = ST_DONE;
      ST_DONE: if (out_free)  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    div_start   = 1'b0;
    cor_start   = 1'b0;
    mul_en      = 1'b0;
    mul_sel_mag = 1'b0;
    wgt_en      = 1'b0;
    sum_en      = 1'b0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        div_start  = in_valid_i && taper_hit;
      end
      ST_DIV:  cor_start = div_done;
      ST_ROT:  ;
      ST_SQR:  mul_en = 1'b1;
      ST_WGT:  wgt_en = 1'b1;
      ST_MAG: begin
        mul_en      = 1'b1;
        mul_sel_mag = 1'b1;
      end
      ST_SUM:  sum_en = 1'b1;
      ST_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  // index advances once per tapered sample and stops at the length
  always_comb begin
    idx_d = idx_q;
    if (in_accept && taper_hit) begin
      idx_d = idx_q + CW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Iterative units: k/N divider and sine CORDIC
  // ---------------------------------------------------------------------------
  cot_div #(
    .COUNT_WIDTH      (CW),
    .WEIGHT_FRAC_BITS (F)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (idx_q),
    .den_i   (taper_n_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // angle: q in Q0.F of a quarter turn, scaled to 2^30 per quarter turn
  assign z0 = $signed(ANG_W'(quo) << (ANG_FRAC - F));

  cot_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .z0_i    (z0),
    .done_o  (cor_done),
    .sin_o   (sin_val)
  );

  // ---------------------------------------------------------------------------
  // Datapath: shared multiplier, weight, product and sum
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] samp_q;
  logic signed [SW:0]   d_q;
  logic                 flag_q;
  logic [F-1:0]         w_q, w_d;
  logic [P_W-1:0]       prod_q;
  logic [MA_W-1:0]      mul_a;
  logic [MB_W-1:0]      mul_b;
  logic [SW:0]          mag;
  logic [SW:0]          trunc_t;
  logic signed [SW+1:0] off_ext;
  logic signed [SW+1:0] t_ext;
  logic signed [SW+1:0] sum_val;
  logic signed [SW-1:0] res_q;

  // |d| fits SW+1 bits unsigned, even for the most negative difference
  assign mag = d_q[SW] ? $unsigned(-d_q) : $unsigned(d_q);

  assign mul_a = mul_sel_mag ? MA_W'(mag) : MA_W'(sin_val);
  assign mul_b = mul_sel_mag ? MB_W'(w_q) : sin_val;

  // weight = sin^2 in Q0.F, saturated just below 1.0
  assign w_d = (|prod_q[P_W-1:2*ANG_FRAC]) ? {F{1'b1}} : prod_q[W_LO +: F];

  // |d|*w >> F truncates toward zero; sign of d restored around the offset
  assign trunc_t = prod_q[F +: SW+1];
  assign off_ext = (SW+2)'(offset_q);
  assign t_ext   = $signed({1'b0, trunc_t});
  assign sum_val = d_q[SW] ? (off_ext - t_ext) : (off_ext + t_ext);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      samp_q <= sample_i;
      d_q    <= (SW+1)'(sample_i) - (SW+1)'(offset_q);
      res_q  <= sample_i;
    end else if (sum_en) begin
      res_q  <= sum_val[SW-1:0];
    end
    if (mul_en) begin
      prod_q <= P_W'(mul_a * mul_b);
    end
    if (wgt_en) begin
      w_q <= w_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q <= 1'b0;
    end else if (in_accept) begin
      flag_q <= taper_hit;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic                 out_valid_q;
  logic signed [SW-1:0] out_sample_q;
  logic                 out_taper_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= res_q;
      out_taper_q  <= flag_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_sample_q;
  assign in_taper_o   = out_taper_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && taper_hit |=> idx_q == CW'($past(idx_q) + CW'(1)))
    else $error("sample index did not advance on a tapered transaction");

  a_idx_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !taper_hit |=> $stable(idx_q))
    else $error("sample index moved on a pass-through transaction");

  a_div_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_cor_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> state_q == ST_ROT)
    else $error("CORDIC finished outside the rotate phase");

  a_pass_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !flag_q |-> res_q == samp_q)
    else $error("pass-through result differs from the input sample");

endmodule

`default_nettype wire

/* rtl/core/cot_div.sv */
// Restoring divider: one quotient bit per cycle, q = floor(num * 2^F / den), num < den.
`default_nettype none

module cot_div #(
  parameter int unsigned COUNT_WIDTH      = 20,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [COUNT_WIDTH-1:0]      num_i,
  input  logic [COUNT_WIDTH-1:0]      den_i,
  output logic                        done_o,
  output logic [WEIGHT_FRAC_BITS-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(WEIGHT_FRAC_BITS);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0]      rem_q, rem_d;
  logic [COUNT_WIDTH-1:0]      den_q, den_d;
  logic [WEIGHT_FRAC_BITS-1:0] quo_q, quo_d;
  logic [COUNT_WIDTH:0]        rem2;
  logic [COUNT_WIDTH:0]        den_ext;
  logic                        fits;

  assign rem2    = {rem_q, 1'b0};
  assign den_ext = {1'b0, den_q};
  assign fits    = (rem2 >= den_ext);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(WEIGHT_FRAC_BITS - 1);
      rem_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      // remainder stays below den, so the top bit drops out after the subtract
      rem_d = fits ? COUNT_WIDTH'(rem2 - den_ext) : rem2[COUNT_WIDTH-1:0];
      quo_d = {quo_q[WEIGHT_FRAC_BITS-2:0], fits};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

/* rtl/core/cot_cordic.sv */
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, clamped sine out.
`default_nettype none

module cot_cordic (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [cot_pkg::ANG_W-1:0]   z0_i,
  output logic                               done_o,
  output logic [cot_pkg::SIN_W-1:0]          sin_o
);

  import cot_pkg::*;

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [STEP_W-1:0]        step_q, step_d;
  logic signed [XY_W-1:0]   x_q, x_d;
  logic signed [XY_W-1:0]   y_q, y_d;
  logic signed [ANG_W-1:0]  z_q, z_d;
  logic signed [XY_W-1:0]   dx;
  logic signed [XY_W-1:0]   dy;
  logic signed [ANG_W-1:0]  ang;

  // barrel shifts of x and y by the step index; >>> floors like the arithmetic shift it models
  assign dx  = y_q >>> step_q;
  assign dy  = x_q >>> step_q;
  assign ang = $signed(ANG_W'(atan_units(step_q)));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      x_d    = CORDIC_X0;
      y_d    = '0;
      z_d    = z0_i;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - ang;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + ang;
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  // clamp to [0, 1.0]
  always_comb begin
    if (y_q < 0) begin
      sin_o = '0;
    end else if (y_q > SIN_ONE) begin
      sin_o = SIN_ONE[SIN_W-1:0];
    end else begin
      sin_o = y_q[SIN_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire
